@@ rtl/mch_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mch_pkg
// shared types and constants of the case folding murmur2 hash block
// ----------------------------------------------------------------------------
package mch_pkg;

	localparam int unsigned LENGTH_BITS = 16;

	localparam logic [31:0] MIX_M      = 32'h5bd1_e995;
	localparam int unsigned MIX_R      = 24;
	localparam int unsigned FIN_A      = 13;
	localparam int unsigned FIN_B      = 15;
	localparam logic [31:0] SEED_RESET = 32'h3141_5926;

	typedef enum logic [0:0] {
		REG_HASH_SEED = 1'b0,
		REG_FOLD_CASE = 1'b1
	} reg_index_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_MIX1,
		OP_MIX2,
		OP_MIX3,
		OP_TAIL,
		OP_FMUL
	} mul_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MIX1,
		ST_MIX2,
		ST_MIX3,
		ST_TAIL,
		ST_FMUL,
		ST_FOUT
	} state_t;

	typedef struct packed {
		logic    accept;
		mul_op_t op;
		logic    load_out;
	} mch_cmd_t;

	typedef struct packed {
		logic mix_req;
		logic fin_req;
	} mch_status_t;

endpackage
`default_nettype wire

@@ rtl/mch_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mch_datapath
// byte folding, word assembly, shared multiplier, counters and result register
// ----------------------------------------------------------------------------
module mch_datapath (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire mch_pkg::mch_cmd_t                   cmd,
	output mch_pkg::mch_status_t                     status,
	input  wire logic                                cfg_we,
	input  wire logic [0:0]                          cfg_index,
	input  wire logic [31:0]                         cfg_data,
	input  wire logic                                start_req,
	input  wire logic [mch_pkg::LENGTH_BITS-1:0]     msg_length,
	input  wire logic                                byte_valid,
	input  wire logic [7:0]                          data_byte,
	input  wire logic                                last,
	output logic [31:0]                              hash_value,
	output logic                                     length_error
);

	logic [31:0] seed_q;
	logic        fold_q;
	logic [31:0] hash_q;
	logic [23:0] word_q;
	logic [1:0]  phase_q;
	logic [mch_pkg::LENGTH_BITS-1:0] seen_q;
	logic [mch_pkg::LENGTH_BITS-1:0] expect_q;
	logic [31:0] k_q;
	logic [31:0] t_q;
	logic [31:0] hash_value_q;
	logic        length_error_q;

	logic [31:0] hash_eff;
	logic [23:0] word_eff;
	logic [1:0]  phase_eff;
	logic [mch_pkg::LENGTH_BITS-1:0] seen_eff;
	logic [7:0]  b;
	logic [23:0] word_nx;
	logic [31:0] mul_a;
	logic [31:0] prod;

	always_comb begin
		hash_eff  = start_req ? (seed_q ^ 32'(msg_length)) : hash_q;
		word_eff  = start_req ? 24'd0 : word_q;
		phase_eff = start_req ? 2'd0 : phase_q;
		seen_eff  = start_req ? '0 : seen_q;
		b = data_byte;
		if (fold_q && (data_byte inside {[8'h41:8'h5a]})) begin
			b = data_byte + 8'd32;
		end
		word_nx = word_eff;
		case (phase_eff)
			2'd0: word_nx[7:0]   = b;
			2'd1: word_nx[15:8]  = b;
			2'd2: word_nx[23:16] = b;
			default: word_nx = word_eff;
		endcase
	end

	assign status.mix_req = byte_valid && (phase_eff == 2'd3);
	assign status.fin_req = last;

	always_comb begin
		case (cmd.op)
			mch_pkg::OP_MIX1: mul_a = k_q;
			mch_pkg::OP_MIX2: mul_a = k_q ^ (k_q >> mch_pkg::MIX_R);
			mch_pkg::OP_MIX3: mul_a = hash_q;
			mch_pkg::OP_TAIL: mul_a = hash_q ^ 32'(word_q);
			mch_pkg::OP_FMUL: mul_a = t_q ^ (t_q >> mch_pkg::FIN_A);
			default:          mul_a = hash_q;
		endcase
	end

	assign prod = mul_a * mch_pkg::MIX_M;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q   <= mch_pkg::SEED_RESET;
			fold_q   <= 1'b1;
			hash_q   <= '0;
			word_q   <= '0;
			phase_q  <= '0;
			seen_q   <= '0;
			expect_q <= '0;
		end else begin
			if (cfg_we) begin
				case (mch_pkg::reg_index_t'(cfg_index))
					mch_pkg::REG_HASH_SEED: seed_q <= cfg_data;
					mch_pkg::REG_FOLD_CASE: fold_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (cmd.accept) begin
				if (start_req) begin
					expect_q <= msg_length;
				end
				hash_q  <= hash_eff;
				word_q  <= word_eff;
				phase_q <= phase_eff;
				seen_q  <= seen_eff;
				if (byte_valid) begin
					if (phase_eff == 2'd3) begin
						word_q  <= '0;
						phase_q <= '0;
					end else begin
						word_q  <= word_nx;
						phase_q <= phase_eff + 2'd1;
					end
					if (seen_eff != '1) begin
						seen_q <= seen_eff + 1'b1;
					end
				end
			end
			if (cmd.op == mch_pkg::OP_MIX3) begin
				hash_q <= prod ^ k_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			k_q <= {b, word_eff};
		end
		case (cmd.op)
			mch_pkg::OP_MIX1: k_q <= prod;
			mch_pkg::OP_MIX2: k_q <= prod;
			mch_pkg::OP_TAIL: t_q <= (phase_q != 2'd0) ? prod : hash_q;
			mch_pkg::OP_FMUL: t_q <= prod;
			default: ;
		endcase
		if (cmd.load_out) begin
			hash_value_q   <= t_q ^ (t_q >> mch_pkg::FIN_B);
			length_error_q <= (seen_q != expect_q);
		end
	end

	assign hash_value   = hash_value_q;
	assign length_error = length_error_q;

endmodule
`default_nettype wire

@@ rtl/mch_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mch_ctrl
// sequencer for word mixing and finish, input and output handshakes
// ----------------------------------------------------------------------------
module mch_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	input  wire mch_pkg::mch_status_t status,
	output mch_pkg::mch_cmd_t         cmd
);

	mch_pkg::state_t state_q, state_nx;
	logic fin_q;
	logic out_valid_q;
	logic out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_nx     = state_q;
		cmd.accept   = 1'b0;
		cmd.op       = mch_pkg::OP_NONE;
		cmd.load_out = 1'b0;
		in_stall     = 1'b1;
		case (state_q)
			mch_pkg::ST_IDLE: begin
				in_stall   = 1'b0;
				cmd.accept = in_valid;
				if (in_valid) begin
					if (status.mix_req) begin
						state_nx = mch_pkg::ST_MIX1;
					end else if (status.fin_req) begin
						state_nx = mch_pkg::ST_TAIL;
					end
				end
			end
			mch_pkg::ST_MIX1: begin
				cmd.op   = mch_pkg::OP_MIX1;
				state_nx = mch_pkg::ST_MIX2;
			end
			mch_pkg::ST_MIX2: begin
				cmd.op   = mch_pkg::OP_MIX2;
				state_nx = mch_pkg::ST_MIX3;
			end
			mch_pkg::ST_MIX3: begin
				cmd.op   = mch_pkg::OP_MIX3;
				state_nx = fin_q ? mch_pkg::ST_TAIL : mch_pkg::ST_IDLE;
			end
			mch_pkg::ST_TAIL: begin
				cmd.op   = mch_pkg::OP_TAIL;
				state_nx = mch_pkg::ST_FMUL;
			end
			mch_pkg::ST_FMUL: begin
				cmd.op   = mch_pkg::OP_FMUL;
				state_nx = mch_pkg::ST_FOUT;
			end
			mch_pkg::ST_FOUT: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_nx     = mch_pkg::ST_IDLE;
				end
			end
			default: state_nx = mch_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mch_pkg::ST_IDLE;
			fin_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.accept) begin
				fin_q <= status.fin_req;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

@@ rtl/murmur2_case_folding_hash.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// murmur2_case_folding_hash
// streaming 32-bit murmur2 hash, one byte per word, optional ascii case folding
// ----------------------------------------------------------------------------
// a byte that leaves a word incomplete is only stored; the fourth byte of a word
// is mixed by three passes through the one shared multiplier
// a last word adds the tail multiply, the avalanche multiply and the output load
// the result sits in an output register while the next word is taken
// reset: asynchronous, active low; hash state clears, seed and fold take defaults
// ----------------------------------------------------------------------------
module murmur2_case_folding_hash (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic                            start_req,
	input  wire logic [mch_pkg::LENGTH_BITS-1:0] msg_length,
	input  wire logic                            byte_valid,
	input  wire logic [7:0]                      data_byte,
	input  wire logic                            last,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [31:0]                          hash_value,
	output logic                                 length_error,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [0:0]                      cfg_index,
	input  wire logic [31:0]                     cfg_data
);

	mch_pkg::mch_cmd_t    cmd;
	mch_pkg::mch_status_t status;

	assign cfg_ready = 1'b1;

	mch_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	mch_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.start_req    (start_req),
		.msg_length   (msg_length),
		.byte_valid   (byte_valid),
		.data_byte    (data_byte),
		.last         (last),
		.hash_value   (hash_value),
		.length_error (length_error)
	);

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the streaming case folding murmur2 hash block: a
// tracker mirrors the hash state for every accepted word and queues the digest
// due on each last word; digests leaving the block are compared in order
// under several seed and fold settings, random idling on both sides and a long
// output hold-off
// ----------------------------------------------------------------------------

localparam logic [7:0] ASCII_UPPER_A = 8'h41;
localparam logic [7:0] ASCII_UPPER_Z = 8'h5a;
localparam logic [7:0] ASCII_CASE_GAP = 8'h20;

typedef struct packed {
	logic [31:0] hash;
	logic        len_err;
} digest_t;

class hash_tracker;
	logic [31:0] seed;
	logic        fold;
	logic [31:0] acc;
	logic [23:0] pend_bytes;
	logic [1:0]  pend_count;
	logic [mch_pkg::LENGTH_BITS-1:0] seen_count;
	logic [mch_pkg::LENGTH_BITS-1:0] stated_len;
	digest_t     expected_digests[$];
	int unsigned mismatches;

	function new();
		seed = mch_pkg::SEED_RESET;
		fold = 1'b1;
		acc = '0;
		pend_bytes = '0;
		pend_count = '0;
		seen_count = '0;
		stated_len = '0;
		mismatches = 0;
	endfunction

	function void set_register(mch_pkg::reg_index_t idx, logic [31:0] data);
		if (idx == mch_pkg::REG_HASH_SEED) begin
			seed = data;
		end else if (idx == mch_pkg::REG_FOLD_CASE) begin
			fold = data[0];
		end
	endfunction

	function void note_word(logic start, logic [mch_pkg::LENGTH_BITS-1:0] len,
			logic bv, logic [7:0] b, logic fin);
		logic [7:0]  c;
		logic [31:0] k;
		logic [31:0] h;
		digest_t     d;
		if (start) begin
			stated_len = len;
			acc = seed ^ 32'(len);
			pend_bytes = '0;
			pend_count = '0;
			seen_count = '0;
		end
		if (bv) begin
			c = b;
			if (fold && c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z)
				c = c + ASCII_CASE_GAP;
			if (pend_count != 2'd3) begin
				pend_bytes = pend_bytes | (24'(c) << (8 * pend_count));
				pend_count = pend_count + 2'd1;
			end else begin
				k = {c, pend_bytes};
				k = k * mch_pkg::MIX_M;
				k = k ^ (k >> mch_pkg::MIX_R);
				k = k * mch_pkg::MIX_M;
				acc = (acc * mch_pkg::MIX_M) ^ k;
				pend_bytes = '0;
				pend_count = '0;
			end
			if (seen_count != '1)
				seen_count = seen_count + 1'b1;
		end
		if (fin) begin
			h = acc;
			if (pend_count != 2'd0)
				h = (h ^ 32'(pend_bytes)) * mch_pkg::MIX_M;
			h = h ^ (h >> mch_pkg::FIN_A);
			h = h * mch_pkg::MIX_M;
			h = h ^ (h >> mch_pkg::FIN_B);
			d.hash = h;
			d.len_err = (seen_count != stated_len);
			expected_digests.push_back(d);
		end
	endfunction

	function void check_digest(logic [31:0] hash, logic len_err);
		digest_t d;
		if (expected_digests.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected digest: hash %h len_err %b", hash, len_err);
			return;
		end
		d = expected_digests.pop_front();
		if (hash !== d.hash || len_err !== d.len_err) begin
			mismatches++;
			if (mismatches <= 10)
				$display("digest mismatch: expected hash %h len_err %b, got hash %h len_err %b",
					d.hash, d.len_err, hash, len_err);
		end
	endfunction

	function int unsigned pending();
		return expected_digests.size();
	endfunction
endclass

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned SETTLE_CYCLES = 12;
	localparam int unsigned HOLD_CYCLES = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic start_req = 1'b0;
	logic [mch_pkg::LENGTH_BITS-1:0] msg_length = '0;
	logic byte_valid = 1'b0;
	logic [7:0] data_byte = '0;
	logic last = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [31:0] hash_value;
	logic length_error;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [0:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	int unsigned idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned words_sent = 0;
	int unsigned cycle_count = 0;
	logic hold_go = 1'b0;
	logic hold_off = 1'b0;

	hash_tracker tracker = new();

	murmur2_case_folding_hash dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.start_req(start_req),
		.msg_length(msg_length),
		.byte_valid(byte_valid),
		.data_byte(data_byte),
		.last(last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.hash_value(hash_value),
		.length_error(length_error),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("murmur2_case_folding_hash verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_stall <= hold_off || ($urandom_range(99) < stall_pct);
	end

	initial begin
		wait (hold_go);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			tracker.check_digest(hash_value, length_error);
	end

	task automatic write_reg(mch_pkg::reg_index_t idx, logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		tracker.set_register(idx, data);
		@(posedge clk);
	endtask

	task automatic send_word(logic start, logic [mch_pkg::LENGTH_BITS-1:0] len,
			logic bv, logic [7:0] b, logic fin);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		start_req <= start;
		msg_length <= len;
		byte_valid <= bv;
		data_byte <= b;
		last <= fin;
		do @(posedge clk); while (in_stall);
		tracker.note_word(start, len, bv, b, fin);
		words_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_byte();
		if ($urandom_range(2) == 0)
			return 8'($urandom_range(8'h3f, 8'h5c));
		return 8'($urandom);
	endfunction

	task automatic send_message(int unsigned max_len);
		int unsigned n;
		int unsigned r;
		int unsigned gap_at;
		logic [mch_pkg::LENGTH_BITS-1:0] stated;
		logic with_start;
		logic with_last;
		r = $urandom_range(99);
		n = ($urandom_range(19) == 0) ? $urandom_range(16, 40) : $urandom_range(0, max_len);
		stated = n[mch_pkg::LENGTH_BITS-1:0];
		with_start = 1'b1;
		with_last = 1'b1;
		gap_at = n + 1;
		if (r < 8)
			stated = 16'($urandom);
		else if (r < 12)
			with_start = 1'b0;
		else if (r < 15)
			with_last = 1'b0;
		else if (r < 19)
			gap_at = $urandom_range(0, n);
		if (n == 0) begin
			send_word(with_start, stated, 1'b0, 8'($urandom), with_last);
		end else begin
			for (int unsigned i = 0; i < n; i++) begin
				if (i == gap_at)
					send_word(1'b0, 16'($urandom), 1'b0, 8'($urandom), 1'b0);
				send_word(with_start && i == 0, (i == 0) ? stated : 16'($urandom),
					1'b1, pick_byte(), with_last && i == n - 1);
			end
		end
	endtask

	task automatic random_phase(int unsigned count, int unsigned in_pct, int unsigned out_pct);
		int unsigned target;
		target = words_sent + count;
		idle_pct = in_pct;
		stall_pct = out_pct;
		while (words_sent < target)
			send_message(9);
		drain();
		idle_pct = 0;
		stall_pct = 0;
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// stream with no start after reset, then an idle word and a last word with a byte
		send_word(1'b0, 16'h1234, 1'b1, 8'h41, 1'b0);
		send_word(1'b0, 16'h0000, 1'b0, 8'h00, 1'b0);
		send_word(1'b0, 16'hffff, 1'b1, 8'h5a, 1'b1);
		// empty messages
		send_word(1'b1, 16'h0000, 1'b0, 8'hff, 1'b1);
		send_word(1'b1, 16'hffff, 1'b0, 8'h00, 1'b1);
		// three byte tail around the letter range
		send_word(1'b1, 16'd3, 1'b1, 8'h40, 1'b0);
		send_word(1'b0, 16'd0, 1'b1, 8'h5b, 1'b0);
		send_word(1'b0, 16'd0, 1'b1, 8'h60, 1'b1);
		// one full word, no tail
		send_word(1'b1, 16'd4, 1'b1, 8'h00, 1'b0);
		send_word(1'b0, 16'd0, 1'b1, 8'hff, 1'b0);
		send_word(1'b0, 16'd0, 1'b1, 8'h7a, 1'b0);
		send_word(1'b0, 16'd0, 1'b1, 8'h61, 1'b1);
		// length mismatch with upper-case letters
		send_word(1'b1, 16'hffff, 1'b1, 8'h41, 1'b0);
		send_word(1'b0, 16'h0000, 1'b1, 8'h42, 1'b0);
		send_word(1'b0, 16'hffff, 1'b1, 8'h59, 1'b0);
		send_word(1'b0, 16'h0000, 1'b1, 8'h5a, 1'b0);
		send_word(1'b0, 16'hffff, 1'b1, 8'h40, 1'b1);
		// bytes after last continue the stream
		send_word(1'b0, 16'h0000, 1'b1, 8'h80, 1'b0);
		send_word(1'b0, 16'h0000, 1'b1, 8'h7f, 1'b1);
		// restart in the middle of a message
		send_word(1'b1, 16'd1, 1'b1, 8'h20, 1'b0);
		send_word(1'b1, 16'd2, 1'b1, 8'h41, 1'b0);
		send_word(1'b0, 16'd0, 1'b1, 8'h5a, 1'b1);
		drain();

		random_phase(200, 0, 0);

		write_reg(mch_pkg::REG_HASH_SEED, 32'h0000_0000);
		write_reg(mch_pkg::REG_FOLD_CASE, 32'h0000_0000);
		random_phase(220, 50, 0);

		write_reg(mch_pkg::REG_HASH_SEED, 32'hffff_ffff);
		write_reg(mch_pkg::REG_FOLD_CASE, 32'hffff_ffff);
		random_phase(220, 0, 50);

		write_reg(mch_pkg::REG_HASH_SEED, $urandom);
		write_reg(mch_pkg::REG_FOLD_CASE, 32'h0000_0000);
		random_phase(220, 27, 27);

		// output held off while short messages keep coming
		write_reg(mch_pkg::REG_HASH_SEED, $urandom);
		write_reg(mch_pkg::REG_FOLD_CASE, 32'h0000_0001);
		hold_go <= 1'b1;
		for (int unsigned i = 0; i < 30; i++)
			send_message(3);
		drain();

		if (tracker.mismatches == 0 && tracker.pending() == 0) begin
			$display("murmur2_case_folding_hash verification clean");
		end else begin
			$display("murmur2_case_folding_hash verification failed");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/mch_pkg.sv
rtl/mch_datapath.sv
rtl/mch_ctrl.sv
rtl/murmur2_case_folding_hash.sv
tb/testbench.sv
